// File: rtl/core/cordic_atan2_degrees_unit_macros.svh
// Assertion macros used by the checker file of the CORDIC phase unit.
`ifndef CORDIC_ATAN2_DEGREES_UNIT_MACROS_SVH
`define CORDIC_ATAN2_DEGREES_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CATAN_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("catan checker: same-cycle property failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CATAN_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("catan checker: next-cycle property failed");

`endif

// File: rtl/core/catan_pkg.sv
// Shared constants, types and the arctangent table of the CORDIC phase unit.
package catan_pkg;

  localparam int DATA_WIDTH     = 16;
  localparam int ITERATIONS     = 13;
  localparam int NORM_THRESHOLD = 2048;
  localparam int ANGLE_W        = 16;
  // Headroom for the negated most negative input and the CORDIC gain.
  localparam int XY_W           = DATA_WIDTH + 4;
  localparam int STEP_W         = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;

  localparam logic [STEP_W-1:0]          LAST_STEP    = STEP_W'(ITERATIONS - 1);
  localparam logic signed [ANGLE_W-1:0]  QUARTER_TURN = ANGLE_W'(9000);
  localparam logic signed [ANGLE_W-1:0]  ANGLE_LIMIT  = ANGLE_W'(18980);
  localparam logic signed [XY_W-1:0]     NORM_LIMIT   = XY_W'(NORM_THRESHOLD);

  typedef struct packed {
    logic              load;
    logic              norm_step;
    logic              iter_step;
    logic              finish;
    logic [STEP_W-1:0] step;
  } catan_cmd_t;

  typedef struct packed {
    logic norm_done;
  } catan_status_t;

  // Arctangent of 2^-i in hundredths of a degree.
  function automatic logic signed [ANGLE_W-1:0] atan_lut(input logic [STEP_W-1:0] idx);
    logic signed [ANGLE_W-1:0] val;
    case (idx)
      4'd0:    val = ANGLE_W'(4500);
      4'd1:    val = ANGLE_W'(2656);
      4'd2:    val = ANGLE_W'(1403);
      4'd3:    val = ANGLE_W'(712);
      4'd4:    val = ANGLE_W'(357);
      4'd5:    val = ANGLE_W'(178);
      4'd6:    val = ANGLE_W'(89);
      4'd7:    val = ANGLE_W'(44);
      4'd8:    val = ANGLE_W'(22);
      4'd9:    val = ANGLE_W'(11);
      4'd10:   val = ANGLE_W'(5);
      4'd11:   val = ANGLE_W'(2);
      4'd12:   val = ANGLE_W'(1);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// File: rtl/core/catan_dpath.sv
// Datapath of the CORDIC phase unit: quadrant fold, normalization and vectoring steps.
module catan_dpath (
  input  logic                                          clk_i,
  input  logic signed [catan_pkg::DATA_WIDTH-1:0]       in_phase_i,
  input  logic signed [catan_pkg::DATA_WIDTH-1:0]       quadrature_i,
  input  catan_pkg::catan_cmd_t                         cmd_i,
  output catan_pkg::catan_status_t                      status_o,
  output logic signed [catan_pkg::ANGLE_W-1:0]          angle_o
);
  import catan_pkg::*;

  logic signed [XY_W-1:0]    x_q, y_q;
  logic signed [ANGLE_W-1:0] acc_q;
  logic signed [ANGLE_W-1:0] angle_q;

  logic signed [XY_W-1:0]    x_ext, y_ext;
  logic signed [XY_W-1:0]    x_load, y_load;
  logic signed [ANGLE_W-1:0] acc_load;
  logic signed [XY_W-1:0]    y_abs, mag;
  logic signed [XY_W-1:0]    x_sh, y_sh;
  logic signed [XY_W-1:0]    x_it, y_it;
  logic signed [ANGLE_W-1:0] acc_it;
  logic signed [ANGLE_W-1:0] lut_val;

  assign x_ext = XY_W'(in_phase_i);
  assign y_ext = XY_W'(quadrature_i);

  // A vector in the left half plane is turned by a quarter turn first.
  always_comb begin
    x_load   = x_ext;
    y_load   = y_ext;
    acc_load = '0;
    if (x_ext < 0) begin
      if (y_ext > 0) begin
        x_load   = y_ext;
        y_load   = -x_ext;
        acc_load = -QUARTER_TURN;
      end else begin
        x_load   = -y_ext;
        y_load   = x_ext;
        acc_load = QUARTER_TURN;
      end
    end
  end

  // The in-phase value is never negative here, so it needs no magnitude.
  assign y_abs = y_q[XY_W-1] ? -y_q : y_q;
  assign mag   = (x_q > y_abs) ? x_q : y_abs;
  assign status_o.norm_done = (mag == '0) || (mag >= NORM_LIMIT);

  assign x_sh    = x_q >>> cmd_i.step;
  assign y_sh    = y_q >>> cmd_i.step;
  assign lut_val = atan_lut(cmd_i.step);

  always_comb begin
    if (!y_q[XY_W-1]) begin
      x_it   = x_q + y_sh;
      y_it   = y_q - x_sh;
      acc_it = acc_q - lut_val;
    end else begin
      x_it   = x_q - y_sh;
      y_it   = y_q + x_sh;
      acc_it = acc_q + lut_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q   <= x_load;
      y_q   <= y_load;
      acc_q <= acc_load;
    end else if (cmd_i.norm_step) begin
      x_q <= x_q <<< 1;
      y_q <= y_q <<< 1;
    end else if (cmd_i.iter_step) begin
      x_q   <= x_it;
      y_q   <= y_it;
      acc_q <= acc_it;
    end
    if (cmd_i.finish) begin
      angle_q <= -acc_it;
    end
  end

  assign angle_o = angle_q;

endmodule

// File: rtl/core/catan_ctrl.sv
// Controller of the CORDIC phase unit: sequences normalization and the vectoring steps.
module catan_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  catan_pkg::catan_status_t status_i,
  output catan_pkg::catan_cmd_t    cmd_o,
  output logic                     busy_o,
  output logic                     done_o
);
  import catan_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_NORM,
    S_ITER
  } state_e;

  state_e            state_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q;
  logic              done_q;

  always_comb begin
    cmd_o.load      = (state_q == S_IDLE) && start_i;
    cmd_o.norm_step = (state_q == S_NORM) && !status_i.norm_done;
    cmd_o.iter_step = (state_q == S_ITER);
    cmd_o.finish    = (state_q == S_ITER) && (step_q == LAST_STEP);
    cmd_o.step      = step_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_NORM;
            busy_q  <= 1'b1;
          end
        end
        S_NORM: begin
          if (status_i.norm_done) begin
            state_q <= S_ITER;
            step_q  <= '0;
          end
        end
        S_ITER: begin
          if (step_q == LAST_STEP) begin
            state_q <= S_IDLE;
            busy_q  <= 1'b0;
            done_q  <= 1'b1;
          end else begin
            step_q <= step_q + STEP_W'(1);
          end
        end
        default: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

// File: rtl/core/cordic_atan2_degrees_unit.sv
// Top level of the CORDIC phase unit: controller and datapath.
// Computes the phase of a signed (in_phase, quadrature) pair in hundredths of a
// degree by CORDIC vectoring. A request is taken at a rising edge with start high
// and busy low; busy then stays high until the result is out. The vector is
// folded into the right half plane as the request is registered, then doubled
// once per cycle until its larger magnitude reaches 2048 (0 to 11 doublings,
// none for a zero vector); once the magnitude is seen in range, one shared
// shift-and-add stage runs the 13 vectoring steps, one per cycle. The angle
// appears on angle_o, registered with the last vectoring step, with done_o high
// for exactly one cycle. The receiver cannot stall the block: angle_o is valid
// only while done_o is high. busy is already low in that cycle, so the next
// request can be taken at the edge that ends it. A zero vector gives 9980.
module cordic_atan2_degrees_unit (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start,
  output logic                                    busy,
  input  logic signed [catan_pkg::DATA_WIDTH-1:0] in_phase_i,
  input  logic signed [catan_pkg::DATA_WIDTH-1:0] quadrature_i,
  output logic signed [catan_pkg::ANGLE_W-1:0]    angle_o,
  output logic                                    done_o
);
  import catan_pkg::*;

  catan_cmd_t    cmd;
  catan_status_t status;

  catan_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  catan_dpath u_dpath (
    .clk_i        (clk_i),
    .in_phase_i   (in_phase_i),
    .quadrature_i (quadrature_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .angle_o      (angle_o)
  );

endmodule

// File: rtl/core/catan_checker.sv
// Port-level checker of the CORDIC phase unit and its bind to the top level.
`include "cordic_atan2_degrees_unit_macros.svh"

module catan_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 start,
  input logic                                 busy,
  input logic signed [catan_pkg::ANGLE_W-1:0] angle_o,
  input logic                                 done_o
);
  import catan_pkg::*;

  logic angle_in_range;

  assign angle_in_range = (angle_o >= -ANGLE_LIMIT) && (angle_o <= ANGLE_LIMIT);

  // A result is only shown once the request has left the unit.
  `CATAN_ASSERT_SAME(a_done_idle, clk_i, rst_ni, done_o, !busy)
  // A taken request makes the unit busy at once.
  `CATAN_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start && !busy, busy)
  // Every request ends with exactly one result strobe.
  `CATAN_ASSERT_SAME(a_fell_done, clk_i, rst_ni, $fell(busy), done_o)
  `CATAN_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o)
  // The angle stays within the reachable range.
  `CATAN_ASSERT_SAME(a_angle_range, clk_i, rst_ni, done_o, angle_in_range)

endmodule

bind cordic_atan2_degrees_unit catan_checker u_catan_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .angle_o (angle_o),
  .done_o  (done_o)
);
